// ===== design/ble_srf_pkg.sv =====
package ble_srf_pkg;

    // table and name limits
    localparam int TABLE_DEPTH = 32;
    localparam int NAME_BUFFER = 100;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 48;

    // result queue between the parser and the output port
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    // advertising structure types that carry a name
    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;
    localparam logic [8:0] NAME_LIMIT       = 9'(NAME_BUFFER);

    // input and result codes
    localparam logic MODE_HEADER  = 1'b0;
    localparam logic MODE_DATA    = 1'b1;
    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SKIP,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_NAME
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } ctrl_state_t;

    // lookup token that travels along the table cells
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [FILL_W-1:0] live;
        logic [ADDR_W-1:0] addr;
    } search_tok_t;

    // commands from the control to the parser
    typedef struct packed {
        logic       start;
        logic       step;
        logic       is_new;
        logic [7:0] len;
        logic [7:0] data;
    } parse_cmd_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic [6:0]  name_length;
        logic        is_new;
        logic        has_name;
        logic [15:0] device_total;
        logic [15:0] named_total;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    name_push;
        logic    sum_push;
        result_t name_res;
        result_t sum_res;
    } parse_out_t;

endpackage

// ===== design/ble_srf_cell.sv =====
module ble_srf_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ble_srf_pkg::search_tok_t           tok_in,
    input  logic                               wr_en,
    input  logic [ble_srf_pkg::ADDR_W-1:0]     wr_addr,
    output ble_srf_pkg::search_tok_t           tok_out
);
    import ble_srf_pkg::*;

    logic [ADDR_W-1:0] entry_reg;
    search_tok_t       tok_reg;
    search_tok_t       tok_next;
    logic              hit;

    // compare the passing token against this entry while it is still live
    always_comb
    begin
        hit      = (tok_in.live != '0) && (entry_reg == tok_in.addr);
        tok_next = tok_in;
        tok_next.found = tok_in.found | hit;
        if (tok_in.live != '0)
        begin
            tok_next.live = tok_in.live - FILL_W'(1);
        end
    end

    // stored address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_addr;
        end
    end

    // hand the token on to the neighbour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/ble_srf_parser.sv =====
module ble_srf_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ble_srf_pkg::parse_cmd_t cmd,
    output ble_srf_pkg::parse_out_t pout
);
    import ble_srf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  pos_reg, pos_next;
    logic [8:0]  nss_reg, nss_next;
    logic [7:0]  slen_reg, slen_next;
    logic        rep_new_reg, rep_new_next;
    logic        rep_named_reg, rep_named_next;
    logic [6:0]  name_len_reg, name_len_next;
    logic [15:0] dev_cnt_reg, dev_cnt_next;
    logic [15:0] named_cnt_reg, named_cnt_next;
    logic [8:0]  pos_inc;
    logic        at_end;
    logic        name_push;
    logic        sum_push;

    // walk of the advertising structures, one byte per step
    always_comb
    begin
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        nss_next       = nss_reg;
        slen_next      = slen_reg;
        rep_new_next   = rep_new_reg;
        rep_named_next = rep_named_reg;
        name_len_next  = name_len_reg;
        dev_cnt_next   = dev_cnt_reg;
        named_cnt_next = named_cnt_reg;
        name_push      = 1'b0;
        sum_push       = 1'b0;
        pos_inc        = {1'b0, pos_reg} + 9'd1;
        at_end         = (pos_inc == nss_reg);

        if (cmd.start)
        begin
            // new report once the address lookup has finished
            rep_new_next   = cmd.is_new;
            rep_named_next = 1'b0;
            name_len_next  = '0;
            if (cmd.is_new)
            begin
                dev_cnt_next = dev_cnt_reg + 16'd1;
            end
            pos_next  = '0;
            nss_next  = '0;
            slen_next = '0;
            rem_next  = cmd.len;
            if (cmd.len == 8'd0)
            begin
                phase_next = PH_IDLE;
                sum_push   = 1'b1;
            end
            else
            begin
                phase_next = cmd.is_new ? PH_LEN : PH_SKIP;
            end
        end
        else if (cmd.step && (phase_reg != PH_IDLE) && (rem_reg != 8'd0))
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    // zero length or a structure past the end stops the walk
                    if ((cmd.data == 8'd0) || (cmd.data >= rem_reg))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        slen_next  = cmd.data;
                        nss_next   = pos_inc + {1'b0, cmd.data};
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if ((cmd.data == AD_NAME_COMPLETE) || (cmd.data == AD_NAME_SHORT))
                    begin
                        if ((slen_reg > 8'd1) && (({1'b0, slen_reg} - 9'd1) < NAME_LIMIT))
                        begin
                            rep_named_next = 1'b1;
                            name_len_next  = 7'(slen_reg - 8'd1);
                            named_cnt_next = named_cnt_reg + 16'd1;
                            phase_next     = PH_NAME;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        phase_next = at_end ? PH_LEN : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (at_end)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_NAME:
                begin
                    name_push = 1'b1;
                    if (at_end)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP, PH_IDLE:
                begin
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            pos_next = pos_reg + 8'd1;
            rem_next = rem_reg - 8'd1;
            if (rem_reg == 8'd1)
            begin
                phase_next = PH_IDLE;
                sum_push   = 1'b1;
            end
        end
    end

    // result beats, built from the updated report state
    always_comb
    begin
        pout.name_push = name_push;
        pout.sum_push  = sum_push;

        pout.name_res.kind         = KIND_NAME;
        pout.name_res.name_byte    = cmd.data;
        pout.name_res.name_length  = rep_named_next ? name_len_next : 7'd0;
        pout.name_res.is_new       = rep_new_next;
        pout.name_res.has_name     = rep_named_next;
        pout.name_res.device_total = dev_cnt_next;
        pout.name_res.named_total  = named_cnt_next;
        pout.name_res.last         = 1'b0;

        pout.sum_res           = pout.name_res;
        pout.sum_res.kind      = KIND_SUMMARY;
        pout.sum_res.name_byte = 8'd0;
        pout.sum_res.last      = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            pos_reg       <= '0;
            nss_reg       <= '0;
            slen_reg      <= '0;
            rep_new_reg   <= 1'b0;
            rep_named_reg <= 1'b0;
            name_len_reg  <= '0;
            dev_cnt_reg   <= '0;
            named_cnt_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            nss_reg       <= nss_next;
            slen_reg      <= slen_next;
            rep_new_reg   <= rep_new_next;
            rep_named_reg <= rep_named_next;
            name_len_reg  <= name_len_next;
            dev_cnt_reg   <= dev_cnt_next;
            named_cnt_reg <= named_cnt_next;
        end
    end

endmodule

// ===== design/ble_scan_report_filter.sv =====
// BLE scan report filter. A header beat (mode 0) starts a lookup of its device address
// in the address table, a row of TABLE_DEPTH cells that a search token crosses one
// cell per cycle, so a header holds the block until its token leaves the last cell;
// an unknown address is written into the next free cell at the end of the walk.
// A data beat (mode 1) is parsed in the cycle it is accepted. Up to two
// result beats (a name byte, then the end-of-report summary) go into a four-entry
// result queue; the input stalls while a lookup runs or while more than two results
// wait. Table cells hold no reset value: only cells already written take part in a
// lookup. Headers that arrive inside an open report drop that report without summary.
module ble_scan_report_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [ble_srf_pkg::ADDR_W-1:0] address,
    input  logic [7:0]                     adv_length,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [7:0]                     name_byte,
    output logic [6:0]                     name_length,
    output logic                           is_new,
    output logic                           has_name,
    output logic [15:0]                    device_total,
    output logic [15:0]                    named_total,
    output logic                           last
);
    import ble_srf_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]    hdr_addr_reg;
    logic [7:0]           hdr_len_reg;
    logic                 inject_reg;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    search_tok_t          tok_chain [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] wr_vec;
    logic                 accept_in;
    logic                 srch_done;
    logic                 tbl_wr;
    parse_cmd_t           cmd;
    parse_out_t           pout;
    result_t              fifo_mem [0:RES_FIFO_DEPTH-1];
    result_t              head_res;
    logic [RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, sum_ptr;
    logic [RES_CNT_W-1:0] fifo_count_reg, n_push;
    logic                 pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && (mode == MODE_HEADER))
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (srch_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // input stall from state and queue room
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   in_stall = (fifo_count_reg > RES_CNT_W'(RES_FIFO_DEPTH - 2));
            ST_SEARCH: in_stall = 1'b1;
            default:   in_stall = 1'b1;
        endcase
    end

    assign accept_in = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            inject_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= accept_in && (mode == MODE_HEADER);
            fill_reg   <= fill_next;
        end
    end

    // header beat held for the lookup
    always_ff @(posedge clk)
    begin
        if (accept_in && (mode == MODE_HEADER))
        begin
            hdr_addr_reg <= address;
            hdr_len_reg  <= adv_length;
        end
    end

    // lookup token enters the first cell
    always_comb
    begin
        tok_chain[0].valid = inject_reg;
        tok_chain[0].found = 1'b0;
        tok_chain[0].live  = fill_reg;
        tok_chain[0].addr  = hdr_addr_reg;
    end

    // table insertion at the end of the walk
    assign srch_done = tok_chain[TABLE_DEPTH].valid;
    assign tbl_wr    = srch_done && !tok_chain[TABLE_DEPTH].found
                       && (fill_reg < FILL_W'(TABLE_DEPTH));
    assign fill_next = tbl_wr ? (fill_reg + FILL_W'(1)) : fill_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            assign wr_vec[gi] = tbl_wr && (fill_reg == FILL_W'(gi));

            ble_srf_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok_chain[gi]),
                .wr_en   (wr_vec[gi]),
                .wr_addr (hdr_addr_reg),
                .tok_out (tok_chain[gi + 1])
            );
        end
    endgenerate

    // parser commands
    always_comb
    begin
        cmd.start  = srch_done;
        cmd.step   = accept_in && (mode == MODE_DATA);
        cmd.is_new = !tok_chain[TABLE_DEPTH].found;
        cmd.len    = hdr_len_reg;
        cmd.data   = data_byte;
    end

    ble_srf_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pout  (pout)
    );

    // result queue, name beat ahead of the summary
    assign pop     = out_valid && !out_stall;
    assign sum_ptr = pout.name_push ? (wr_ptr_reg + RES_PTR_W'(1)) : wr_ptr_reg;
    assign n_push  = RES_CNT_W'(pout.name_push) + RES_CNT_W'(pout.sum_push);

    always_ff @(posedge clk)
    begin
        if (pout.name_push)
        begin
            fifo_mem[wr_ptr_reg] <= pout.name_res;
        end
        if (pout.sum_push)
        begin
            fifo_mem[sum_ptr] <= pout.sum_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_reg + RES_PTR_W'(n_push);
            rd_ptr_reg     <= rd_ptr_reg + RES_PTR_W'(pop);
            fifo_count_reg <= fifo_count_reg + n_push - RES_CNT_W'(pop);
        end
    end

    // output beat
    assign head_res     = fifo_mem[rd_ptr_reg];
    assign out_valid    = (fifo_count_reg != '0);
    assign kind         = head_res.kind;
    assign name_byte    = head_res.name_byte;
    assign name_length  = head_res.name_length;
    assign is_new       = head_res.is_new;
    assign has_name     = head_res.has_name;
    assign device_total = head_res.device_total;
    assign named_total  = head_res.named_total;
    assign last         = head_res.last;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= RES_CNT_W'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> (state_reg == ST_SEARCH))
        else $error("lookup finished outside a search");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_DEPTH))
        else $error("table fill beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("table write did not advance fill");

endmodule

// ===== dv/ble_scan_report_filter_test.sv =====
module ble_scan_report_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ble_srf_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        len;
        logic [7:0]        data;
    } scan_beat_t;

    typedef struct packed {
        scan_beat_t beat;
        logic       typed;
        result_t    want;
    } directed_row_t;

    localparam result_t NO_RESULT = '0;

    // ports
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [7:0]        adv_length;
    logic [7:0]        data_byte;
    logic              out_valid;
    logic              out_stall;
    logic              kind;
    logic [7:0]        name_byte;
    logic [6:0]        name_length;
    logic              is_new;
    logic              has_name;
    logic [15:0]       device_total;
    logic [15:0]       named_total;
    logic              last;

    ble_scan_report_filter dut (.*);

    always #5 clk = ~clk;

    // directed reports: odd beats, name and broken-structure walks, known device, dropped report
    directed_row_t directed_rows[27] = '{
        '{'{MODE_DATA,   48'h0,              8'd0, 8'hFF},            1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'h0,              8'd0, 8'h00},            1'b1,
          '{KIND_SUMMARY, 8'h00, 7'd0, 1'b1, 1'b0, 16'd1, 16'd0, 1'b1}},
        '{'{MODE_HEADER, 48'h0,              8'd0, 8'hFF},            1'b1,
          '{KIND_SUMMARY, 8'h00, 7'd0, 1'b0, 1'b0, 16'd1, 16'd0, 1'b1}},
        '{'{MODE_HEADER, 48'hFFFF_FFFF_FFFF, 8'd6, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h05},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, AD_NAME_COMPLETE}, 1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h42},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h4C},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h45},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h21},            1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'hFFFF_FFFF_FFFF, 8'd2, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'hFF},            1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'h1234_5678_9ABC, 8'd3, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, AD_NAME_SHORT},    1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h01},            1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'h8000_0000_0001, 8'd2, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h05},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, AD_NAME_COMPLETE}, 1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'h0000_0000_0002, 8'd3, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h01},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, AD_NAME_SHORT},    1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'h5555_AAAA_5555, 8'd4, 8'h00},            1'b0, NO_RESULT},
        '{'{MODE_DATA,   48'h0,              8'd0, 8'h03},            1'b0, NO_RESULT},
        '{'{MODE_HEADER, 48'h0000_0000_0003, 8'd0, 8'h00},            1'b0, NO_RESULT}
    };

    // filter state as the predictor sees it
    logic [ADDR_W-1:0] stored_addrs[TABLE_DEPTH];
    int                stored_count  = 0;
    logic [15:0]       new_devices   = '0;
    logic [15:0]       named_devices = '0;
    logic [7:0]        walk_pos      = '0;
    logic [8:0]        struct_end    = '0;
    logic [7:0]        struct_len    = '0;
    phase_t            walk_phase    = PH_IDLE;
    logic [7:0]        bytes_left    = '0;
    logic              rep_new       = 1'b0;
    logic              rep_named     = 1'b0;
    logic [7:0]        rep_name_len  = '0;

    result_t           step_results[$];
    result_t           results_due[$];
    result_t           due;
    scan_beat_t        report_beats[$];
    logic [ADDR_W-1:0] seen_pool[$];

    int   failures      = 0;
    int   burst_left    = 0;
    int   report_items  = 0;
    int   cycle_count   = 0;
    logic hold_off_due  = 1'b0;

    // one result beat built from the current report flags
    function automatic result_t report_result(logic kind_bit, logic [7:0] nbyte,
                                              logic last_bit);
        result_t r;
        r.kind         = kind_bit;
        r.name_byte    = nbyte;
        r.name_length  = rep_named ? rep_name_len[6:0] : 7'd0;
        r.is_new       = rep_new;
        r.has_name     = rep_named;
        r.device_total = new_devices;
        r.named_total  = named_devices;
        r.last         = last_bit;
        return r;
    endfunction

    // lookup, table update and advertising structure walk for one accepted beat
    function automatic void predict_filter_results(scan_beat_t b);
        logic       hit;
        logic [7:0] pos;
        step_results.delete();
        if (b.mode == MODE_HEADER)
        begin
            hit = 1'b0;
            for (int i = 0; i < stored_count; i++)
                if (stored_addrs[i] == b.addr)
                    hit = 1'b1;
            rep_new      = !hit;
            rep_named    = 1'b0;
            rep_name_len = '0;
            if (rep_new)
            begin
                if (stored_count < TABLE_DEPTH)
                begin
                    stored_addrs[stored_count] = b.addr;
                    stored_count++;
                end
                new_devices++;
            end
            walk_pos   = '0;
            struct_end = '0;
            struct_len = '0;
            bytes_left = b.len;
            if (b.len == 8'd0)
            begin
                walk_phase = PH_IDLE;
                step_results.push_back(report_result(KIND_SUMMARY, 8'h00, 1'b1));
            end
            else if (rep_new)
                walk_phase = PH_LEN;
            else
                walk_phase = PH_SKIP;
            return;
        end

        // data beat outside an open report is dropped
        if (walk_phase == PH_IDLE || bytes_left == 8'd0)
            return;

        pos = walk_pos;
        case (walk_phase)
            PH_LEN:
            begin
                if (b.data == 8'd0 || int'(b.data) + 1 > int'(bytes_left))
                    walk_phase = PH_SKIP;
                else
                begin
                    struct_len = b.data;
                    struct_end = {1'b0, pos} + {1'b0, b.data} + 9'd1;
                    walk_phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (b.data == AD_NAME_COMPLETE || b.data == AD_NAME_SHORT)
                begin
                    if (struct_len > 8'd1 && int'(struct_len) - 1 < NAME_BUFFER)
                    begin
                        rep_named    = 1'b1;
                        rep_name_len = struct_len - 8'd1;
                        named_devices++;
                        walk_phase   = PH_NAME;
                    end
                    else
                        walk_phase = PH_SKIP;
                end
                else if ({1'b0, pos} + 9'd1 == struct_end)
                    walk_phase = PH_LEN;
                else
                    walk_phase = PH_DATA;
            end
            PH_DATA:
            begin
                if ({1'b0, pos} + 9'd1 == struct_end)
                    walk_phase = PH_LEN;
            end
            PH_NAME:
            begin
                step_results.push_back(report_result(KIND_NAME, b.data, 1'b0));
                if ({1'b0, pos} + 9'd1 == struct_end)
                    walk_phase = PH_SKIP;
            end
            default:
            begin
            end
        endcase

        walk_pos = pos + 8'd1;
        bytes_left--;
        if (bytes_left == 8'd0)
        begin
            walk_phase = PH_IDLE;
            step_results.push_back(report_result(KIND_SUMMARY, 8'h00, 1'b1));
        end
    endfunction

    // offer one beat in bursts with random gaps, then book its results
    task automatic send_beat(scan_beat_t b, logic typed, result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        mode       <= b.mode;
        address    <= b.addr;
        adv_length <= b.len;
        data_byte  <= b.data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_filter_results(b);
        if (typed)
            results_due.push_back(want);
        else
            foreach (step_results[k])
                results_due.push_back(step_results[k]);
    endtask

    // stop offering and wait for every booked result
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    // one random report: mostly well formed structures, some noise and breakage
    task automatic build_random_report();
        logic [ADDR_W-1:0] addr;
        logic [7:0]        body[$];
        int                style;
        int                n_struct;
        int                pick;
        int                sl;
        int                keep;
        scan_beat_t        b;
        report_beats.delete();

        // device seen before or a fresh one
        if (seen_pool.size() != 0 && $urandom_range(0, 2) == 0)
            addr = seen_pool[$urandom_range(0, seen_pool.size() - 1)];
        else
        begin
            addr = {16'($urandom), $urandom};
            seen_pool.push_back(addr);
        end

        style = $urandom_range(0, 39);
        if (style == 0)
        begin
            // long raw body
            sl = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(100, 254);
            repeat (sl) body.push_back(8'($urandom));
        end
        else if (style == 1)
        begin
            // name at and just past the buffer limit
            sl = $urandom_range(99, 101);
            body.push_back(8'(sl));
            body.push_back($urandom_range(0, 1) ? AD_NAME_COMPLETE : AD_NAME_SHORT);
            repeat (sl - 1) body.push_back(8'($urandom));
        end
        else if (style > 4)
        begin
            n_struct = $urandom_range(1, 4);
            for (int s = 0; s < n_struct; s++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    // zero length byte, junk after it
                    body.push_back(8'h00);
                    repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
                end
                else if (pick < 8)
                begin
                    sl = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                    body.push_back(8'(sl));
                    body.push_back($urandom_range(0, 1) ? AD_NAME_COMPLETE
                                                        : AD_NAME_SHORT);
                    repeat (sl - 1) body.push_back(8'($urandom));
                end
                else
                begin
                    sl = $urandom_range(1, 6);
                    body.push_back(8'(sl));
                    body.push_back(8'($urandom));
                    repeat (sl - 1) body.push_back(8'($urandom));
                end
            end
            // structure running past the end of the report
            if ($urandom_range(0, 7) == 0)
            begin
                body.push_back(8'($urandom_range(3, 40)));
                repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
            end
        end
        while (body.size() > 255)
            void'(body.pop_back());

        b.mode = MODE_HEADER;
        b.addr = addr;
        b.len  = 8'(body.size());
        b.data = 8'($urandom);
        report_beats.push_back(b);

        // now and then cut the report short so the next header drops it
        keep = body.size();
        if (keep > 0 && $urandom_range(0, 11) == 0)
            keep = $urandom_range(0, keep - 1);
        for (int j = 0; j < keep; j++)
        begin
            b.mode = MODE_DATA;
            b.addr = {16'($urandom), $urandom};
            b.len  = 8'($urandom);
            b.data = body[j];
            report_beats.push_back(b);
        end
    endtask

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
        end
    endfunction

    // result side: compare each accepted beat with the oldest booking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result beat: kind %0d name_byte %0h", kind, name_byte);
                failures++;
            end
            else
            begin
                due = results_due.pop_front();
                check_field("kind", due.kind, kind);
                check_field("name_byte", due.name_byte, name_byte);
                check_field("name_length", due.name_length, name_length);
                check_field("is_new", due.is_new, is_new);
                check_field("has_name", due.has_name, has_name);
                check_field("device_total", due.device_total, device_total);
                check_field("named_total", due.named_total, named_total);
                check_field("last", due.last, last);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : receiver
        int phase_left;
        int stall_pct;
        int hold_left;
        phase_left = 0;
        stall_pct  = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_due)
            begin
                hold_off_due = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 15;
                        2:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                phase_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // sender: reset, directed table, random reports, end of run
    initial
    begin : sender
        scan_beat_t stray;
        logic       hold_off_sent;
        logic       pause_done;
        hold_off_sent = 1'b0;
        pause_done    = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        mode       <= MODE_HEADER;
        address    <= '0;
        adv_length <= '0;
        data_byte  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        while (report_items < ITEM_TARGET)
        begin
            // block fills while the receiver holds off
            if (!hold_off_sent && report_items > 500)
            begin
                hold_off_due  = 1'b1;
                hold_off_sent = 1'b1;
            end
            if (!pause_done && report_items > 1000)
            begin
                drain_results();
                pause_done = 1'b1;
            end
            // stray data beat between reports
            if ($urandom_range(0, 14) == 0)
            begin
                stray.mode = MODE_DATA;
                stray.addr = {16'($urandom), $urandom};
                stray.len  = 8'($urandom);
                stray.data = 8'($urandom);
                send_beat(stray, 1'b0, NO_RESULT);
            end
            build_random_report();
            foreach (report_beats[j])
            begin
                send_beat(report_beats[j], 1'b0, NO_RESULT);
                report_items++;
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
